/* rtl/spwa_pkg.sv */
// Shared constants and helpers for the sorted position weight aggregator.
// Holds default widths, the fixed sum and weight widths and the command word size.
// Depends on nothing; every other file imports it.
package spwa_pkg;

  // Default transcript id and position widths
  localparam int DEF_ID_BITS  = 16;
  localparam int DEF_POS_BITS = 24;

  // Fixed field widths
  localparam int WEIGHT_W = 32;
  localparam int SUM_W    = 48;

  // Depth of the queue between the front and back parts
  localparam int CMD_DEPTH = 4;

  // Bits of one emit descriptor: valid, ends, split, tid, pos, sum, pad, count
  function automatic int desc_bits(input int id_bits, input int pos_bits);
    desc_bits = 3 + id_bits + SUM_W + 3 * pos_bits + 1;
  endfunction

  // A command carries two descriptors: the run closed by the item, and the flush
  function automatic int cmd_bits(input int id_bits, input int pos_bits);
    cmd_bits = 2 * desc_bits(id_bits, pos_bits);
  endfunction

endpackage

/* rtl/spwa_front.sv */
// Front part: accepts records, merges runs and classifies what must be emitted.
// Produces one command word per record that closes a run or flushes the block.
// Depends on spwa_pkg.
module spwa_front #(
  parameter int ID_BITS  = spwa_pkg::DEF_ID_BITS,
  parameter int POS_BITS = spwa_pkg::DEF_POS_BITS,
  parameter int CMD_W    = spwa_pkg::cmd_bits(ID_BITS, POS_BITS)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [ID_BITS-1:0]            transcript_index,
  input  logic [POS_BITS-1:0]           position,
  input  logic [spwa_pkg::WEIGHT_W-1:0] weight,
  input  logic [POS_BITS:0]             transcript_length,
  input  logic                          last_item,
  output logic                          cmd_push,
  input  logic                          cmd_full,
  output logic [CMD_W-1:0]              cmd_data
);
  import spwa_pkg::*;

  typedef struct packed {
    logic                vld;
    logic                ends;
    logic                split;
    logic [ID_BITS-1:0]  tid;
    logic [POS_BITS-1:0] pos;
    logic [SUM_W-1:0]    sum;
    logic [POS_BITS-1:0] pad;
    logic [POS_BITS:0]   cnt;
  } desc_t;

  localparam logic [POS_BITS:0] CNT_MAX = '1;

  // Saturating entry counter step
  function automatic logic [POS_BITS:0] count_up(input logic [POS_BITS:0] c);
    count_up = (c == CNT_MAX) ? CNT_MAX : c + 1'b1;
  endfunction

  // Run state
  logic                run_valid;
  logic [ID_BITS-1:0]  run_transcript;
  logic [POS_BITS-1:0] run_position;
  logic [SUM_W-1:0]    run_sum;
  logic [POS_BITS:0]   run_length;
  logic [POS_BITS:0]   entries_so_far;

  logic                accept;
  logic                same_t;
  logic                same_p;
  logic [SUM_W:0]      sum_wide;
  logic [SUM_W-1:0]    sum_sat;
  logic [POS_BITS:0]   len_m1;
  logic [POS_BITS:0]   cnt_a;
  logic [POS_BITS-1:0] run_position_next;
  logic [SUM_W-1:0]    run_sum_next;
  logic [POS_BITS:0]   run_length_next;
  logic [POS_BITS:0]   entries_so_far_next;
  logic [POS_BITS:0]   len_m1_b;
  logic [POS_BITS:0]   cnt_b;
  desc_t               cmd_a;
  desc_t               cmd_b;

  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  // Classify the record against the open run
  assign same_t   = run_valid && (transcript_index == run_transcript);
  assign same_p   = (position == run_position);
  assign sum_wide = {1'b0, run_sum} + {{(SUM_W + 1 - WEIGHT_W){1'b0}}, weight};
  assign sum_sat  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];

  // Descriptor for the run this record closes
  assign len_m1 = run_length - 1'b1;
  assign cnt_a  = count_up(entries_so_far);

  always_comb begin
    cmd_a.vld   = run_valid && (!same_t || !same_p);
    cmd_a.ends  = !same_t;
    cmd_a.tid   = run_transcript;
    cmd_a.pos   = run_position;
    cmd_a.sum   = run_sum;
    cmd_a.pad   = len_m1[POS_BITS-1:0];
    cmd_a.split = !same_t && (run_position != len_m1[POS_BITS-1:0]);
    cmd_a.cnt   = cmd_a.split ? count_up(cnt_a) : cnt_a;
  end

  // State after merging the record
  always_comb begin
    run_position_next = position;
    if (same_t) begin
      run_length_next     = run_length;
      run_sum_next        = same_p ? sum_sat : {{(SUM_W - WEIGHT_W){1'b0}}, weight};
      entries_so_far_next = same_p ? entries_so_far : cnt_a;
    end else begin
      run_length_next     = transcript_length;
      run_sum_next        = {{(SUM_W - WEIGHT_W){1'b0}}, weight};
      entries_so_far_next = '0;
    end
  end

  // Descriptor for the flush on the last record
  assign len_m1_b = run_length_next - 1'b1;
  assign cnt_b    = count_up(entries_so_far_next);

  always_comb begin
    cmd_b.vld   = last_item;
    cmd_b.ends  = 1'b1;
    cmd_b.tid   = transcript_index;
    cmd_b.pos   = run_position_next;
    cmd_b.sum   = run_sum_next;
    cmd_b.pad   = len_m1_b[POS_BITS-1:0];
    cmd_b.split = (run_position_next != len_m1_b[POS_BITS-1:0]);
    cmd_b.cnt   = cmd_b.split ? count_up(cnt_b) : cnt_b;
  end

  assign cmd_push = accept && (cmd_a.vld || last_item);
  assign cmd_data = {cmd_a, cmd_b};

  // Advance the run state on each transaction; drop it after a flush
  always_ff @(posedge clk) begin
    if (rst || (accept && last_item)) begin
      run_valid      <= 1'b0;
      run_transcript <= '0;
      run_position   <= '0;
      run_sum        <= '0;
      run_length     <= '0;
      entries_so_far <= '0;
    end else if (accept) begin
      run_valid      <= 1'b1;
      run_transcript <= transcript_index;
      run_position   <= run_position_next;
      run_sum        <= run_sum_next;
      run_length     <= run_length_next;
      entries_so_far <= entries_so_far_next;
    end
  end

endmodule

/* rtl/spwa_cmd_fifo.sv */
// Short command queue between the front and back parts.
// Register-based, head read directly; depth from the package.
// Depends on spwa_pkg.
module spwa_cmd_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = spwa_pkg::CMD_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             empty
);
  import spwa_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rptr];

  // Store incoming commands
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == LAST_PTR) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == LAST_PTR) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/spwa_back.sv */
// Back part: expands each command into one to four result entries.
// Steps through run and padding entries and holds them in an output register.
// Depends on spwa_pkg.
module spwa_back #(
  parameter int ID_BITS  = spwa_pkg::DEF_ID_BITS,
  parameter int POS_BITS = spwa_pkg::DEF_POS_BITS,
  parameter int CMD_W    = spwa_pkg::cmd_bits(ID_BITS, POS_BITS)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [CMD_W-1:0]           cmd_data,
  input  logic                       cmd_empty,
  output logic                       cmd_pop,
  output logic                       empty,
  input  logic                       pop,
  output logic [ID_BITS-1:0]         out_transcript_index,
  output logic [POS_BITS-1:0]        out_position,
  output logic [spwa_pkg::SUM_W-1:0] summed_weight,
  output logic                       end_of_transcript,
  output logic [POS_BITS:0]          entry_count,
  output logic                       end_of_stream
);
  import spwa_pkg::*;

  typedef struct packed {
    logic                vld;
    logic                ends;
    logic                split;
    logic [ID_BITS-1:0]  tid;
    logic [POS_BITS-1:0] pos;
    logic [SUM_W-1:0]    sum;
    logic [POS_BITS-1:0] pad;
    logic [POS_BITS:0]   cnt;
  } desc_t;

  typedef struct packed {
    desc_t a;
    desc_t b;
  } cmd_t;

  typedef enum logic [1:0] {
    STEP_A_RUN,
    STEP_A_PAD,
    STEP_B_RUN,
    STEP_B_PAD
  } step_t;

  cmd_t                cmd;
  step_t               step;
  step_t               cur;
  step_t               nxt;
  logic                out_valid;
  logic                load;
  logic                done;
  logic [ID_BITS-1:0]  r_tid;
  logic [POS_BITS-1:0] r_pos;
  logic [SUM_W-1:0]    r_sum;
  logic                r_eot;
  logic [POS_BITS:0]   r_cnt;

  assign cmd = cmd_data;

  // Skip the closed-run entries when the command only flushes
  assign cur = (step == STEP_A_RUN && !cmd.a.vld) ? STEP_B_RUN : step;

  // Build the entry for the current step
  always_comb begin
    r_tid = cmd.a.tid;
    r_pos = cmd.a.pos;
    r_sum = cmd.a.sum;
    r_eot = 1'b0;
    r_cnt = '0;
    done  = 1'b1;
    nxt   = STEP_A_RUN;
    case (cur)
      STEP_A_RUN: begin
        r_eot = cmd.a.ends && !cmd.a.split;
        r_cnt = r_eot ? cmd.a.cnt : '0;
        done  = !cmd.a.split && !cmd.b.vld;
        nxt   = cmd.a.split ? STEP_A_PAD : STEP_B_RUN;
      end
      STEP_A_PAD: begin
        r_pos = cmd.a.pad;
        r_sum = '0;
        r_eot = 1'b1;
        r_cnt = cmd.a.cnt;
        done  = !cmd.b.vld;
        nxt   = STEP_B_RUN;
      end
      STEP_B_RUN: begin
        r_tid = cmd.b.tid;
        r_pos = cmd.b.pos;
        r_sum = cmd.b.sum;
        r_eot = !cmd.b.split;
        r_cnt = r_eot ? cmd.b.cnt : '0;
        done  = !cmd.b.split;
        nxt   = STEP_B_PAD;
      end
      STEP_B_PAD: begin
        r_tid = cmd.b.tid;
        r_pos = cmd.b.pad;
        r_sum = '0;
        r_eot = 1'b1;
        r_cnt = cmd.b.cnt;
        done  = 1'b1;
        nxt   = STEP_A_RUN;
      end
      default: begin
        done = 1'b1;
        nxt  = STEP_A_RUN;
      end
    endcase
  end

  assign load    = !cmd_empty && (!out_valid || pop);
  assign cmd_pop = load && done;
  assign empty   = !out_valid;

  // Hold the step and the output entry; advance when the slot frees up
  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= STEP_A_RUN;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        step      <= done ? STEP_A_RUN : nxt;
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
    if (load) begin
      out_transcript_index <= r_tid;
      out_position         <= r_pos;
      summed_weight        <= r_sum;
      end_of_transcript    <= r_eot;
      entry_count          <= r_cnt;
      end_of_stream        <= done && (cur == STEP_B_RUN || cur == STEP_B_PAD);
    end
  end

endmodule

/* rtl/sorted_position_weight_aggregator_unit.sv */
// Sorted position weight aggregator: sums weights per distinct position of a
// transcript-sorted record stream and closes each transcript with a count.
//
// Input channel: a record is taken on a clock edge with push high and full low.
// Result channel: while empty is low the oldest entry sits on the result ports;
// pop high on a clock edge takes it.
// A position's entry comes out after the record that ends its run (a new
// position, a new transcript or last_item). A closing transcript adds a zero
// padding entry at length-1 unless the last position already was length-1;
// the final entry carries end_of_transcript and entry_count. last_item flushes
// everything and marks the final entry with end_of_stream.
// Throughput: one record per cycle while full is low. Each result occupies the
// output register until popped, so a record causing up to four results holds
// the back end until all are taken. The front merge and command queue write
// happen at the accepting edge; the output register loads once it is free.
// Reset (rst, synchronous) drops the open run, empties the four-entry command
// queue and the output register. While the receiver stalls the output register
// holds; the command queue fills and full rises when it has no room left.
// Depends on spwa_pkg, spwa_front, spwa_cmd_fifo, spwa_back.
module sorted_position_weight_aggregator_unit #(
  parameter int ID_BITS  = spwa_pkg::DEF_ID_BITS,
  parameter int POS_BITS = spwa_pkg::DEF_POS_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [ID_BITS-1:0]            transcript_index,
  input  logic [POS_BITS-1:0]           position,
  input  logic [spwa_pkg::WEIGHT_W-1:0] weight,
  input  logic [POS_BITS:0]             transcript_length,
  input  logic                          last_item,
  output logic                          empty,
  input  logic                          pop,
  output logic [ID_BITS-1:0]            out_transcript_index,
  output logic [POS_BITS-1:0]           out_position,
  output logic [spwa_pkg::SUM_W-1:0]    summed_weight,
  output logic                          end_of_transcript,
  output logic [POS_BITS:0]             entry_count,
  output logic                          end_of_stream
);
  import spwa_pkg::*;

  localparam int CMD_W = cmd_bits(ID_BITS, POS_BITS);

  logic             cmd_push;
  logic             cmd_full;
  logic [CMD_W-1:0] cmd_in;
  logic [CMD_W-1:0] cmd_head;
  logic             cmd_empty;
  logic             cmd_pop;

  // Merge records and classify emits
  spwa_front #(
    .ID_BITS  (ID_BITS),
    .POS_BITS (POS_BITS),
    .CMD_W    (CMD_W)
  ) u_front (
    .clk               (clk),
    .rst               (rst),
    .push              (push),
    .full              (full),
    .transcript_index  (transcript_index),
    .position          (position),
    .weight            (weight),
    .transcript_length (transcript_length),
    .last_item         (last_item),
    .cmd_push          (cmd_push),
    .cmd_full          (cmd_full),
    .cmd_data          (cmd_in)
  );

  // Decouple front and back
  spwa_cmd_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .head      (cmd_head),
    .empty     (cmd_empty)
  );

  // Expand commands into result entries
  spwa_back #(
    .ID_BITS  (ID_BITS),
    .POS_BITS (POS_BITS),
    .CMD_W    (CMD_W)
  ) u_back (
    .clk                  (clk),
    .rst                  (rst),
    .cmd_data             (cmd_head),
    .cmd_empty            (cmd_empty),
    .cmd_pop              (cmd_pop),
    .empty                (empty),
    .pop                  (pop),
    .out_transcript_index (out_transcript_index),
    .out_position         (out_position),
    .summed_weight        (summed_weight),
    .end_of_transcript    (end_of_transcript),
    .entry_count          (entry_count),
    .end_of_stream        (end_of_stream)
  );

endmodule
